>>> hw/rtl/cse_pkg.sv
`timescale 1ns / 1ps
// Package for the capability string extractor: character codes, parse mode
// and outcome codes, register indexes and field widths. No dependencies.
package cse_pkg;

    // Field widths
    localparam int CHAR_W    = 8;
    localparam int OUTCOME_W = 2;
    localparam int MODE_W    = 4;
    localparam int CFG_IDX_W = 1;

    // Parse modes
    localparam logic [MODE_W-1:0] MODE_SKIP_NAME   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_FIELD_START = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SECOND      = 4'd2;
    localparam logic [MODE_W-1:0] MODE_SKIP_FIELD  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_EQUALS      = 4'd4;
    localparam logic [MODE_W-1:0] MODE_VALUE       = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ESCAPE      = 4'd6;
    localparam logic [MODE_W-1:0] MODE_OCT_MID     = 4'd7;
    localparam logic [MODE_W-1:0] MODE_OCT_LAST    = 4'd8;
    localparam logic [MODE_W-1:0] MODE_CARET       = 4'd9;
    localparam logic [MODE_W-1:0] MODE_DONE        = 4'd10;

    // Outcome codes
    localparam logic [OUTCOME_W-1:0] OC_GOING     = 2'd0;
    localparam logic [OUTCOME_W-1:0] OC_COMPLETE  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OC_ABSENT    = 2'd2;
    localparam logic [OUTCOME_W-1:0] OC_NOT_STRNG = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAP_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_SECOND = 1'd1;

    // Characters
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
    localparam logic [CHAR_W-1:0] CH_COLON     = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_EQUALS    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_CARET     = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_AT        = 8'h40;
    localparam logic [CHAR_W-1:0] CH_UNDERLINE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SEVEN     = 8'h37;
    localparam logic [CHAR_W-1:0] CH_ESC       = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_LC_N      = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_LC_R      = 8'h72;
    localparam logic [CHAR_W-1:0] CH_LC_B      = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LC_F      = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LC_T      = 8'h74;
    localparam logic [CHAR_W-1:0] CH_UC_E      = 8'h45;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;

    // Outcome reported when the entry ends while in the given mode
    function automatic logic [OUTCOME_W-1:0] end_outcome(input logic [MODE_W-1:0] mode);
        logic [OUTCOME_W-1:0] oc;
        if (mode == MODE_EQUALS) begin
            oc = OC_NOT_STRNG;
        end else if (mode >= MODE_VALUE && mode <= MODE_CARET) begin
            oc = OC_COMPLETE;
        end else begin
            oc = OC_ABSENT;
        end
        return oc;
    endfunction

endpackage

>>> hw/rtl/capability_string_extractor.sv
`timescale 1ns / 1ps
// Capability string extractor: scans a capability entry one byte per
// transaction and emits the decoded value of the configured capability.
// Depends on cse_pkg.
//
// Channel   Direction  Payload
// s_axis    in         tdata = char_in, tlast = entry_end
// m_axis    out        tdata = out_byte, tuser = {outcome, byte_valid}
// cfg       in         index = register, data = 8-bit value
//
// One byte per cycle: the parse step is a single mode update between the
// state registers and the result register. Each byte yields zero or one
// result. A two-deep output (result register plus skid register) lets
// input keep flowing while m_axis stalls; s_axis stalls only when both
// are full. Reset (synchronous, active low) clears the parse state, the
// capability name and the output stages. The cfg channel is always ready.
module capability_string_extractor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input byte stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [cse_pkg::CHAR_W-1:0]     i_s_axis_tdata,   // [7:0] char_in
    input  logic                           i_s_axis_tlast,
    // Result stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [cse_pkg::CHAR_W-1:0]     o_m_axis_tdata,   // [7:0] out_byte
    output logic [cse_pkg::OUTCOME_W:0]    o_m_axis_tuser,   // [0] byte_valid, [2:1] outcome
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cse_pkg::CHAR_W-1:0]     i_cfg_data
);
    import cse_pkg::*;

    localparam int RES_W = CHAR_W + OUTCOME_W + 1;

    // Capability name registers
    logic [CHAR_W-1:0]    r_cap_first;
    logic [CHAR_W-1:0]    r_cap_second;

    // Parse state
    logic [MODE_W-1:0]    r_mode, n_mode;
    logic [CHAR_W-1:0]    r_held, n_held;
    logic [CHAR_W-1:0]    r_oct,  n_oct;

    // Output stages
    logic                 r_out_valid;
    logic [RES_W-1:0]     r_out_data;
    logic                 r_skid_valid;
    logic [RES_W-1:0]     r_skid_data;

    // Step results
    logic [CHAR_W-1:0]    res_byte;
    logic                 res_bvalid;
    logic [OUTCOME_W-1:0] res_oc;
    logic                 res_valid;
    logic [CHAR_W-1:0]    c;
    logic [CHAR_W-1:0]    digit;
    logic                 in_fire;
    logic                 out_fire;

    assign c        = i_s_axis_tdata;
    assign digit    = c - CH_ZERO;
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = r_out_valid && i_m_axis_tready;

    assign o_s_axis_tready = !r_skid_valid;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data[CHAR_W-1:0];
    assign o_m_axis_tuser  = r_out_data[RES_W-1:CHAR_W];

    // Parse step for the byte on the input
    always_comb begin
        n_mode     = r_mode;
        n_held     = r_held;
        n_oct      = r_oct;
        res_byte   = '0;
        res_bvalid = 1'b0;
        res_oc     = OC_GOING;
        res_valid  = 1'b0;
        if (r_mode >= MODE_DONE) begin
            // outcome already given: swallow bytes until the entry ends
            if (i_s_axis_tlast) begin
                n_mode = MODE_SKIP_NAME;
                n_held = '0;
                n_oct  = '0;
            end
        end else begin
            if (c == CH_NUL) begin
                // a zero byte ends the entry
                res_oc = end_outcome(r_mode);
            end else begin
                unique case (r_mode)
                    MODE_SKIP_NAME, MODE_SKIP_FIELD: begin
                        if (c == CH_COLON) n_mode = MODE_FIELD_START;
                    end
                    MODE_FIELD_START: begin
                        if (c == r_cap_first) begin
                            n_held = c;
                            n_mode = MODE_SECOND;
                        end else if (c == CH_COLON) begin
                            n_mode = MODE_FIELD_START;
                        end else begin
                            n_mode = MODE_SKIP_FIELD;
                        end
                    end
                    MODE_SECOND: begin
                        if (c == r_cap_second) begin
                            n_mode = MODE_EQUALS;
                        end else if (r_held == CH_COLON) begin
                            // a colon matched the first letter: this byte opens a field
                            if (c == r_cap_first) begin
                                n_held = c;
                                n_mode = MODE_SECOND;
                            end else if (c == CH_COLON) begin
                                n_mode = MODE_FIELD_START;
                            end else begin
                                n_mode = MODE_SKIP_FIELD;
                            end
                        end else if (c == CH_COLON) begin
                            n_mode = MODE_FIELD_START;
                        end else begin
                            n_mode = MODE_SKIP_FIELD;
                        end
                    end
                    MODE_EQUALS: begin
                        if (c == CH_EQUALS) n_mode = MODE_VALUE;
                        else                res_oc = OC_NOT_STRNG;
                    end
                    MODE_VALUE: begin
                        if (c == CH_BACKSLASH) begin
                            n_mode = MODE_ESCAPE;
                        end else if (c == CH_CARET) begin
                            n_mode = MODE_CARET;
                        end else if (c == CH_COLON) begin
                            res_oc = OC_COMPLETE;
                        end else begin
                            res_byte   = c;
                            res_bvalid = 1'b1;
                        end
                    end
                    MODE_ESCAPE: begin
                        n_mode     = MODE_VALUE;
                        res_bvalid = 1'b1;
                        if (c == CH_LC_N) begin
                            res_byte = CH_NEWLINE;
                        end else if (c == CH_LC_R) begin
                            res_byte = CH_RETURN;
                        end else if (c == CH_LC_B) begin
                            res_byte = CH_BACKSPACE;
                        end else if (c == CH_LC_F) begin
                            res_byte = CH_FORMFEED;
                        end else if (c == CH_LC_T) begin
                            res_byte = CH_TAB;
                        end else if (c == CH_UC_E) begin
                            res_byte = CH_ESC;
                        end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
                            // first octal digit lands in the top two bits
                            n_oct      = {digit[1:0], 6'b0};
                            n_mode     = MODE_OCT_MID;
                            res_bvalid = 1'b0;
                        end else begin
                            res_byte = c;
                        end
                    end
                    MODE_OCT_MID: begin
                        n_oct  = r_oct + {digit[CHAR_W-4:0], 3'b0};
                        n_mode = MODE_OCT_LAST;
                    end
                    MODE_OCT_LAST: begin
                        res_byte   = r_oct + digit;
                        res_bvalid = 1'b1;
                        n_oct      = '0;
                        n_mode     = MODE_VALUE;
                    end
                    MODE_CARET: begin
                        if (c >= CH_AT && c <= CH_UNDERLINE) begin
                            res_byte   = c - CH_AT;
                            res_bvalid = 1'b1;
                        end
                        n_mode = MODE_VALUE;
                    end
                    default: begin
                    end
                endcase
            end
            // end of entry: outcome follows the mode after this byte
            if (res_oc == OC_GOING && i_s_axis_tlast) begin
                res_oc = end_outcome(n_mode);
            end
            if (i_s_axis_tlast) begin
                n_mode = MODE_SKIP_NAME;
                n_held = '0;
                n_oct  = '0;
            end else if (res_oc != OC_GOING) begin
                n_mode = MODE_DONE;
            end
            res_valid = res_bvalid || (res_oc != OC_GOING);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_first  <= '0;
            r_cap_second <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_CAP_FIRST:  r_cap_first  <= i_cfg_data;
                REG_CAP_SECOND: r_cap_second <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Parse state update on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SKIP_NAME;
            r_held <= '0;
            r_oct  <= '0;
        end else if (in_fire) begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_oct  <= n_oct;
        end
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_fire) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_fire && res_valid) begin
                if (!r_out_valid || out_fire) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the output stages
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) r_out_data <= r_skid_data;
        end else if (in_fire && res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out_data <= {res_oc, res_bvalid, res_byte};
            end else begin
                r_skid_data <= {res_oc, res_bvalid, res_byte};
            end
        end
    end

`ifndef ASSERT_OFF
    // skid stage only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds data while output register is empty");

    // every result carries a byte or an outcome
    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser[0] || o_m_axis_tuser[2:1] != OC_GOING))
        else $error("empty result presented");

    // last byte of an entry returns the parser to the name field
    a_entry_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_s_axis_tlast) |=> (r_mode == MODE_SKIP_NAME))
        else $error("parser not restarted after end of entry");

    // a stalled result is not dropped or altered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled result changed");
`endif

endmodule
